// File: sv/kpl_pkg.sv
// Shared types, constants and the microcode program of the keypad passcode lock.
`default_nettype none

package kpl_pkg;

	localparam int KEY_LENGTH = 4;
	localparam int KEY_W      = 8;
	localparam int LEN_W      = $clog2(KEY_LENGTH + 1);
	localparam int IDX_W      = (KEY_LENGTH > 1) ? $clog2(KEY_LENGTH) : 1;
	localparam int ATT_W      = 8;
	localparam int EVERY_W    = 4;
	localparam int WAIT_W     = 16;
	localparam int TICKS_W    = 32;
	localparam int EXP_W      = 4;
	localparam int DCNT_W     = $clog2(ATT_W);
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int PC_W       = 5;

	localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;
	localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;
	localparam logic [KEY_W-1:0] KEY_0    = 8'h30;
	localparam logic [KEY_W-1:0] KEY_9    = 8'h39;
	localparam logic [KEY_W-1:0] KEY_A    = 8'h41;
	localparam logic [KEY_W-1:0] KEY_D    = 8'h44;

	localparam logic [EVERY_W-1:0] EVERY_RST = 4'd3;
	localparam logic [WAIT_W-1:0]  WAIT_RST  = 16'd5000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCKOUT_EVERY = 1'b0,
		CFG_WAIT_UNIT     = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_UNLOCK = 2'd0,
		MODE_VERIFY = 2'd1,
		MODE_NEW    = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_NONE       = 4'd0,
		ST_TAKEN      = 4'd1,
		ST_REMOVED    = 4'd2,
		ST_UNLOCKED   = 4'd3,
		ST_WRONG      = 4'd4,
		ST_LOCKED     = 4'd5,
		ST_CHANGE     = 4'd6,
		ST_OLD_OK     = 4'd7,
		ST_NEW_STORED = 4'd8
	} status_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_PUSH,
		OP_POP,
		OP_SET_VERIFY,
		OP_SET_NEW,
		OP_STORE,
		OP_CLEAR,
		OP_UNLOCK,
		OP_TICK,
		OP_WRONG,
		OP_DIV,
		OP_LOCK,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NONE,
		C_TICK,
		C_LOCKED,
		C_HASH,
		C_STAR,
		C_ENTRY,
		C_LONG,
		C_NOT_FULL,
		C_EMPTY,
		C_MODE2,
		C_MATCH,
		C_MODE1,
		C_DIV_MORE
	} cond_t;

	typedef struct packed {
		op_t             op;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic            done;
		status_t         status;
	} ctrl_t;

	typedef struct packed {
		op_t     op;
		logic    load;
		logic    emit;
		status_t status;
	} seq_ctl_t;

	typedef struct packed {
		logic tick;
		logic locked;
		logic hash;
		logic star;
		logic entry_ok;
		logic long_start;
		logic not_full;
		logic empty;
		logic mode2;
		logic match;
		logic mode1;
		logic div_more;
	} dp_flags_t;

	localparam logic [PC_W-1:0] S_DECODE  = 5'd0;
	localparam logic [PC_W-1:0] S_LOCKCHK = 5'd1;
	localparam logic [PC_W-1:0] S_HASHCHK = 5'd2;
	localparam logic [PC_W-1:0] S_STARCHK = 5'd3;
	localparam logic [PC_W-1:0] S_KEYCHK  = 5'd4;
	localparam logic [PC_W-1:0] S_NOTHING = 5'd5;
	localparam logic [PC_W-1:0] S_HASH    = 5'd6;
	localparam logic [PC_W-1:0] S_FULLCHK = 5'd7;
	localparam logic [PC_W-1:0] S_MODECHK = 5'd8;
	localparam logic [PC_W-1:0] S_CMP     = 5'd9;
	localparam logic [PC_W-1:0] S_WRONG   = 5'd10;
	localparam logic [PC_W-1:0] S_DIV     = 5'd11;
	localparam logic [PC_W-1:0] S_LOCK    = 5'd12;
	localparam logic [PC_W-1:0] S_STAR    = 5'd13;
	localparam logic [PC_W-1:0] S_POP     = 5'd14;
	localparam logic [PC_W-1:0] S_PUSH    = 5'd15;
	localparam logic [PC_W-1:0] S_CHANGE  = 5'd16;
	localparam logic [PC_W-1:0] S_STORE   = 5'd17;
	localparam logic [PC_W-1:0] S_MATCH   = 5'd18;
	localparam logic [PC_W-1:0] S_UNLOCK  = 5'd19;
	localparam logic [PC_W-1:0] S_OLD_OK  = 5'd20;
	localparam logic [PC_W-1:0] S_TICK    = 5'd21;
	localparam logic [PC_W-1:0] S_LOCKED  = 5'd22;
	localparam logic [PC_W-1:0] S_EMIT    = 5'd23;

	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t cw;
		case (pc)
			S_DECODE:  cw = '{OP_NOP,        C_TICK,     S_TICK,    1'b0, ST_NONE};
			S_LOCKCHK: cw = '{OP_NOP,        C_LOCKED,   S_LOCKED,  1'b0, ST_NONE};
			S_HASHCHK: cw = '{OP_NOP,        C_HASH,     S_HASH,    1'b0, ST_NONE};
			S_STARCHK: cw = '{OP_NOP,        C_STAR,     S_STAR,    1'b0, ST_NONE};
			S_KEYCHK:  cw = '{OP_NOP,        C_ENTRY,    S_PUSH,    1'b0, ST_NONE};
			S_NOTHING: cw = '{OP_NOP,        C_NONE,     S_EMIT,    1'b1, ST_NONE};
			S_HASH:    cw = '{OP_NOP,        C_LONG,     S_CHANGE,  1'b0, ST_NONE};
			S_FULLCHK: cw = '{OP_NOP,        C_NOT_FULL, S_NOTHING, 1'b0, ST_NONE};
			S_MODECHK: cw = '{OP_NOP,        C_MODE2,    S_STORE,   1'b0, ST_NONE};
			S_CMP:     cw = '{OP_NOP,        C_MATCH,    S_MATCH,   1'b0, ST_NONE};
			S_WRONG:   cw = '{OP_WRONG,      C_NONE,     S_EMIT,    1'b0, ST_NONE};
			S_DIV:     cw = '{OP_DIV,        C_DIV_MORE, S_DIV,     1'b0, ST_NONE};
			S_LOCK:    cw = '{OP_LOCK,       C_NONE,     S_EMIT,    1'b1, ST_WRONG};
			S_STAR:    cw = '{OP_NOP,        C_EMPTY,    S_NOTHING, 1'b0, ST_NONE};
			S_POP:     cw = '{OP_POP,        C_NONE,     S_EMIT,    1'b1, ST_REMOVED};
			S_PUSH:    cw = '{OP_PUSH,       C_NONE,     S_EMIT,    1'b1, ST_TAKEN};
			S_CHANGE:  cw = '{OP_SET_VERIFY, C_NONE,     S_EMIT,    1'b1, ST_CHANGE};
			S_STORE:   cw = '{OP_STORE,      C_NONE,     S_EMIT,    1'b1, ST_NEW_STORED};
			S_MATCH:   cw = '{OP_CLEAR,      C_MODE1,    S_OLD_OK,  1'b0, ST_NONE};
			S_UNLOCK:  cw = '{OP_UNLOCK,     C_NONE,     S_EMIT,    1'b1, ST_UNLOCKED};
			S_OLD_OK:  cw = '{OP_SET_NEW,    C_NONE,     S_EMIT,    1'b1, ST_OLD_OK};
			S_TICK:    cw = '{OP_TICK,       C_NONE,     S_EMIT,    1'b1, ST_NONE};
			S_LOCKED:  cw = '{OP_NOP,        C_NONE,     S_EMIT,    1'b1, ST_LOCKED};
			S_EMIT:    cw = '{OP_EMIT,       C_NONE,     S_DECODE,  1'b0, ST_NONE};
			default:   cw = '{OP_NOP,        C_NONE,     S_EMIT,    1'b1, ST_NONE};
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

// File: sv/kpl_intf.sv
// Request and result channel interfaces of the keypad passcode lock.
`default_nettype none

interface kpl_req_if;
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [kpl_pkg::KEY_W-1:0]  key_code;
	logic                       long_press;

	modport source (output valid, command, key_code, long_press, input ready);
	modport sink   (input valid, command, key_code, long_press, output ready);
endinterface

interface kpl_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [3:0]                   status;
	logic [kpl_pkg::LEN_W-1:0]    entered_count;
	logic [kpl_pkg::ATT_W-1:0]    attempt_count;
	logic                         locked_out;
	logic [1:0]                   entry_mode;
	logic [kpl_pkg::TICKS_W-1:0]  ticks_left;

	modport source (output valid, status, entered_count, attempt_count, locked_out,
		entry_mode, ticks_left, input ready);
	modport sink   (input valid, status, entered_count, attempt_count, locked_out,
		entry_mode, ticks_left, output ready);
endinterface

`default_nettype wire

// File: sv/kpl_useq.sv
// Microcode sequencer: step counter, control ROM, condition select and handshake.
`default_nettype none

module kpl_useq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire kpl_pkg::dp_flags_t flags,
	output kpl_pkg::seq_ctl_t       ctl
);

	logic [kpl_pkg::PC_W-1:0] pc_q;
	logic [kpl_pkg::PC_W-1:0] pc_nxt;
	logic                     busy_q;
	logic                     busy_nxt;
	logic                     out_valid_q;
	kpl_pkg::status_t         status_q;
	kpl_pkg::status_t         status_nxt;
	kpl_pkg::ctrl_t           cw;
	logic                     cond_true;
	logic                     slot_free;
	logic                     in_acc;
	logic                     emit;

	assign cw        = kpl_pkg::ucode(pc_q);
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = !busy_q;
	assign in_acc    = in_valid && !busy_q;
	assign emit      = busy_q && (cw.op == kpl_pkg::OP_EMIT) && slot_free;
	assign out_valid = out_valid_q;

	always_comb begin
		case (cw.cond)
			kpl_pkg::C_NONE:     cond_true = 1'b0;
			kpl_pkg::C_TICK:     cond_true = flags.tick;
			kpl_pkg::C_LOCKED:   cond_true = flags.locked;
			kpl_pkg::C_HASH:     cond_true = flags.hash;
			kpl_pkg::C_STAR:     cond_true = flags.star;
			kpl_pkg::C_ENTRY:    cond_true = flags.entry_ok;
			kpl_pkg::C_LONG:     cond_true = flags.long_start;
			kpl_pkg::C_NOT_FULL: cond_true = flags.not_full;
			kpl_pkg::C_EMPTY:    cond_true = flags.empty;
			kpl_pkg::C_MODE2:    cond_true = flags.mode2;
			kpl_pkg::C_MATCH:    cond_true = flags.match;
			kpl_pkg::C_MODE1:    cond_true = flags.mode1;
			kpl_pkg::C_DIV_MORE: cond_true = flags.div_more;
			default:             cond_true = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		pc_nxt     = pc_q;
		busy_nxt   = busy_q;
		status_nxt = status_q;
		if (!busy_q) begin
			if (in_acc) begin
				busy_nxt = 1'b1;
				pc_nxt   = kpl_pkg::S_DECODE;
			end
		end else if (cw.op == kpl_pkg::OP_EMIT) begin
			if (slot_free) begin
				busy_nxt = 1'b0;
				pc_nxt   = kpl_pkg::S_DECODE;
			end
		end else if (cw.done) begin
			pc_nxt     = kpl_pkg::S_EMIT;
			status_nxt = cw.status;
		end else if (cond_true) begin
			pc_nxt = cw.target;
		end else begin
			pc_nxt = pc_q + kpl_pkg::PC_W'(1);
		end
	end

	// datapath control
	always_comb begin
		ctl.op     = (busy_q && cw.op != kpl_pkg::OP_EMIT) ? cw.op : kpl_pkg::OP_NOP;
		ctl.load   = in_acc;
		ctl.emit   = emit;
		ctl.status = status_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= kpl_pkg::S_DECODE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= kpl_pkg::ST_NONE;
		end else begin
			pc_q     <= pc_nxt;
			busy_q   <= busy_nxt;
			status_q <= status_nxt;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/kpl_dpath.sv
// Datapath: key buffers, counters, lockout timer, serial divider and result register.
`default_nettype none

module kpl_dpath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire kpl_pkg::seq_ctl_t               ctl,
	input  wire logic                            in_command,
	input  wire logic [kpl_pkg::KEY_W-1:0]       in_key_code,
	input  wire logic                            in_long_press,
	input  wire logic                            cfg_we,
	input  wire logic [kpl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [kpl_pkg::CFG_W-1:0]       cfg_data,
	output kpl_pkg::dp_flags_t                   flags,
	output logic [3:0]                           status,
	output logic [kpl_pkg::LEN_W-1:0]            entered_count,
	output logic [kpl_pkg::ATT_W-1:0]            attempt_count,
	output logic                                 locked_out,
	output logic [1:0]                           entry_mode,
	output logic [kpl_pkg::TICKS_W-1:0]          ticks_left
);

	localparam int KL = kpl_pkg::KEY_LENGTH;
	localparam int KW = kpl_pkg::KEY_W;

	logic                              cmd_q;
	logic [KW-1:0]                     key_q;
	logic                              lp_q;
	logic [KW-1:0]                     entry_q  [KL];
	logic [KW-1:0]                     stored_q [KL];
	logic [kpl_pkg::LEN_W-1:0]         len_q;
	logic [kpl_pkg::ATT_W-1:0]         att_q;
	logic [kpl_pkg::TICKS_W-1:0]       lock_q;
	kpl_pkg::mode_t                    mode_q;
	logic [kpl_pkg::EVERY_W-1:0]       every_q;
	logic [kpl_pkg::WAIT_W-1:0]        wait_q;
	logic [kpl_pkg::EVERY_W-1:0]       rem_q;
	logic [kpl_pkg::ATT_W-1:0]         quo_q;
	logic [kpl_pkg::DCNT_W-1:0]        dcnt_q;
	logic [3:0]                        res_status_q;
	logic [kpl_pkg::LEN_W-1:0]         res_len_q;
	logic [kpl_pkg::ATT_W-1:0]         res_att_q;
	logic                              res_locked_q;
	logic [1:0]                        res_mode_q;
	logic [kpl_pkg::TICKS_W-1:0]       res_ticks_q;

	logic [KL*KW-1:0]                  entry_flat;
	logic [KL*KW-1:0]                  stored_flat;
	logic                              is_key;
	logic [kpl_pkg::ATT_W-1:0]         att_inc;
	logic [kpl_pkg::EVERY_W-1:0]       d_eff;
	logic [kpl_pkg::EVERY_W:0]         div_trial;
	logic                              div_ge;
	logic [kpl_pkg::EVERY_W:0]         div_diff;
	logic [kpl_pkg::EVERY_W-1:0]       rem_nxt;
	logic [kpl_pkg::EXP_W-1:0]         lock_exp;
	logic [kpl_pkg::TICKS_W-1:0]       lock_load;
	logic                              lock_hit;

	always_comb begin
		for (int i = 0; i < KL; i++) begin
			entry_flat[i*KW +: KW]  = entry_q[i];
			stored_flat[i*KW +: KW] = stored_q[i];
		end
	end

	assign is_key = ((key_q >= kpl_pkg::KEY_0) && (key_q <= kpl_pkg::KEY_9))
		|| ((key_q >= kpl_pkg::KEY_A) && (key_q <= kpl_pkg::KEY_D));

	always_comb begin
		flags.tick       = cmd_q;
		flags.locked     = (lock_q != '0);
		flags.hash       = (key_q == kpl_pkg::KEY_HASH);
		flags.star       = (key_q == kpl_pkg::KEY_STAR);
		flags.entry_ok   = is_key && (len_q < kpl_pkg::LEN_W'(KL));
		flags.long_start = lp_q && (len_q == '0) && (mode_q != kpl_pkg::MODE_VERIFY)
			&& (mode_q != kpl_pkg::MODE_NEW);
		flags.not_full   = (len_q != kpl_pkg::LEN_W'(KL));
		flags.empty      = (len_q == '0);
		flags.mode2      = (mode_q == kpl_pkg::MODE_NEW);
		flags.match      = (entry_flat == stored_flat);
		flags.mode1      = (mode_q == kpl_pkg::MODE_VERIFY);
		flags.div_more   = (dcnt_q != kpl_pkg::DCNT_W'(kpl_pkg::ATT_W - 1));
	end

	// saturating attempt count and restoring divide step
	assign att_inc   = (att_q == '1) ? att_q : att_q + kpl_pkg::ATT_W'(1);
	assign d_eff     = (every_q == '0) ? kpl_pkg::EVERY_W'(1) : every_q;
	assign div_trial = {rem_q, quo_q[kpl_pkg::ATT_W-1]};
	assign div_ge    = (div_trial >= {1'b0, d_eff});
	assign div_diff  = div_trial - {1'b0, d_eff};
	assign rem_nxt   = div_ge ? div_diff[kpl_pkg::EVERY_W-1:0]
		: div_trial[kpl_pkg::EVERY_W-1:0];

	assign lock_exp  = (quo_q > kpl_pkg::ATT_W'(16)) ? kpl_pkg::EXP_W'(15)
		: kpl_pkg::EXP_W'(quo_q - kpl_pkg::ATT_W'(1));
	assign lock_load = kpl_pkg::TICKS_W'(wait_q) << lock_exp;
	assign lock_hit  = (att_q > kpl_pkg::ATT_W'(1)) && (rem_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			att_q   <= '0;
			lock_q  <= '0;
			mode_q  <= kpl_pkg::MODE_NEW;
			every_q <= kpl_pkg::EVERY_RST;
			wait_q  <= kpl_pkg::WAIT_RST;
			dcnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (kpl_pkg::cfg_idx_t'(cfg_index))
					kpl_pkg::CFG_LOCKOUT_EVERY: every_q <= cfg_data[kpl_pkg::EVERY_W-1:0];
					kpl_pkg::CFG_WAIT_UNIT:     wait_q  <= cfg_data[kpl_pkg::WAIT_W-1:0];
					default:                    ;
				endcase
			end
			case (ctl.op)
				kpl_pkg::OP_PUSH:       len_q  <= len_q + kpl_pkg::LEN_W'(1);
				kpl_pkg::OP_POP:        len_q  <= len_q - kpl_pkg::LEN_W'(1);
				kpl_pkg::OP_SET_VERIFY: mode_q <= kpl_pkg::MODE_VERIFY;
				kpl_pkg::OP_SET_NEW:    mode_q <= kpl_pkg::MODE_NEW;
				kpl_pkg::OP_STORE: begin
					mode_q <= kpl_pkg::MODE_UNLOCK;
					att_q  <= '0;
					len_q  <= '0;
				end
				kpl_pkg::OP_CLEAR:      len_q  <= '0;
				kpl_pkg::OP_UNLOCK:     att_q  <= '0;
				kpl_pkg::OP_TICK: begin
					if (lock_q != '0) begin
						lock_q <= lock_q - kpl_pkg::TICKS_W'(1);
					end
				end
				kpl_pkg::OP_WRONG: begin
					att_q  <= att_inc;
					len_q  <= '0;
					dcnt_q <= '0;
				end
				kpl_pkg::OP_DIV:        dcnt_q <= dcnt_q + kpl_pkg::DCNT_W'(1);
				kpl_pkg::OP_LOCK: begin
					if (lock_hit) begin
						lock_q <= lock_load;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= in_command;
			key_q <= in_key_code;
			lp_q  <= in_long_press;
		end
		if (ctl.op == kpl_pkg::OP_PUSH) begin
			entry_q[len_q[kpl_pkg::IDX_W-1:0]] <= key_q;
		end
		if (ctl.op == kpl_pkg::OP_STORE) begin
			for (int i = 0; i < KL; i++) begin
				stored_q[i] <= entry_q[i];
			end
		end
		if (ctl.op == kpl_pkg::OP_WRONG) begin
			rem_q <= '0;
			quo_q <= att_inc;
		end else if (ctl.op == kpl_pkg::OP_DIV) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[kpl_pkg::ATT_W-2:0], div_ge};
		end
		if (ctl.emit) begin
			res_status_q <= ctl.status;
			res_len_q    <= len_q;
			res_att_q    <= att_q;
			res_locked_q <= (lock_q != '0);
			res_mode_q   <= mode_q;
			res_ticks_q  <= lock_q;
		end
	end

	assign status        = res_status_q;
	assign entered_count = res_len_q;
	assign attempt_count = res_att_q;
	assign locked_out    = res_locked_q;
	assign entry_mode    = res_mode_q;
	assign ticks_left    = res_ticks_q;

endmodule

`default_nettype wire

// File: sv/keypad_passcode_lock_unit.sv
// Top level of the keypad passcode lock: sequencer, datapath and channel wiring.
//
// Channel  Dir  Handshake      Contents
// req      in   valid/ready    command, key_code, long_press
// rsp      out  valid/ready    status, entered_count, attempt_count, locked_out,
//                              entry_mode, ticks_left
// cfg      in   cfg_we         cfg_index, cfg_data (0 lockout_every, 1 wait_unit_ticks)
//
// A request runs from acceptance to its result through the microcode steps: a tick
// takes the shortest path, a key is turned away early while locked out, and a wrong
// entry goes through the one-bit-a-cycle divider that finds the lockout point. The
// microcode step counter runs one request at a time.
// Reset leaves the lock asking for a first key; key stores are undefined until written.
// A waiting result sits in the result register; a stalled rsp holds the sequencer
// at its final step, and req is ready again once that result is registered.
`default_nettype none

module keypad_passcode_lock_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	kpl_req_if.sink                                  req,
	kpl_rsp_if.source                                rsp,
	input  wire logic                                cfg_we,
	input  wire logic [kpl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [kpl_pkg::CFG_W-1:0]           cfg_data
);

	kpl_pkg::seq_ctl_t  ctl;
	kpl_pkg::dp_flags_t flags;

	kpl_useq u_useq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.flags     (flags),
		.ctl       (ctl)
	);

	kpl_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.in_command    (req.command),
		.in_key_code   (req.key_code),
		.in_long_press (req.long_press),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.flags         (flags),
		.status        (rsp.status),
		.entered_count (rsp.entered_count),
		.attempt_count (rsp.attempt_count),
		.locked_out    (rsp.locked_out),
		.entry_mode    (rsp.entry_mode),
		.ticks_left    (rsp.ticks_left)
	);

endmodule

`default_nettype wire
